@@ hw/rtl/rgbc_pkg.sv @@
// rgbc_pkg: shared types and constants for the 3x3 rgb convolution filter
// no dependencies; imported by the filter datapath, the top level and the checker
`default_nettype none

package rgbc_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = COL_W + 1;
  localparam int HGT_W = ROW_W + 1;

  // blur scale 0.111 as a 16 bit fraction
  localparam logic [12:0] BLUR_MUL = 13'd7274;

  // result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;
  // three results each for the new item and the two in flight
  localparam int ACCEPT_MAX = FIFO_DEPTH - 9;

  // filter modes
  localparam logic [1:0] MODE_BLUR    = 2'd0;
  localparam logic [1:0] MODE_EMBOSS  = 2'd1;
  localparam logic [1:0] MODE_SHARPEN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic [7:0]       alpha_out;
    logic             last_of_run;
  } pix_out_t;

  // 3x3 window of packed pixels {a, b, g, r}
  typedef logic [8:0][31:0] win_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgbc_filter.sv @@
// rgbc_filter: blur / emboss / sharpen kernel over one 3x3 window, three channels
// depends on rgbc_pkg
`default_nettype none

module rgbc_filter (
  input  rgbc_pkg::win_t     win,
  input  logic [1:0]         mode,
  output logic [23:0]        rgb
);
  import rgbc_pkg::*;

  function automatic logic [7:0] clamp_u8(input logic signed [12:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 13'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [7:0]         p [9];
    logic [11:0]        usum;
    logic [24:0]        prod;
    logic signed [12:0] emb;
    logic signed [12:0] shp;

    // unpack this channel from the window
    always_comb begin
      for (int i = 0; i < 9; i++) begin
        p[i] = win[i][8*k +: 8];
      end
    end

    // blur: plain sum scaled by the fixed point reciprocal
    always_comb begin
      usum = 12'd0;
      for (int i = 0; i < 9; i++) begin
        usum = usum + {4'd0, p[i]};
      end
      prod = 25'(usum) * 25'(BLUR_MUL);
    end

    // emboss and sharpen kernels
    always_comb begin
      emb = 13'sd128
          + $signed({5'd0, p[4]}) + $signed({5'd0, p[5]})
          + $signed({5'd0, p[7]}) + $signed({4'd0, p[8], 1'b0})
          - $signed({4'd0, p[0], 1'b0})
          - $signed({5'd0, p[1]}) - $signed({5'd0, p[3]});
      shp = $signed({3'd0, p[4], 2'd0}) + $signed({5'd0, p[4]})
          - $signed({5'd0, p[1]}) - $signed({5'd0, p[3]})
          - $signed({5'd0, p[5]}) - $signed({5'd0, p[7]});
    end

    // mode select; the unused code acts as blur
    always_comb begin
      case (mode)
        MODE_EMBOSS:  rgb[8*k +: 8] = clamp_u8(emb);
        MODE_SHARPEN: rgb[8*k +: 8] = clamp_u8(shp);
        default:      rgb[8*k +: 8] = prod[23:16];
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rgb_conv3x3_filter.sv @@
// rgb_conv3x3_filter: top level of the streaming 3x3 rgba convolution filter
// depends on rgbc_pkg and rgbc_filter
`default_nettype none

// Takes one raster-order RGBA pixel per clock and produces filtered pixels
// with their coordinates. A pixel (c, r) releases pixel (c-1, r-1); the last
// column also releases (c, r-1), and pixels of the last row come out as they
// arrive, so one input yields up to three results, the final one flagged by
// last_of_run. Sustained rate is one input per cycle; it is bounded by the
// single read/write port pair of each line store, which is read when a pixel
// is taken and written back in the following cycle (a bypass covers
// one-pixel-wide frames). The first result of a pixel passes the stage 1
// and stage 2 registers and the result queue before it shows on the output.
// The end of a row with extra results, or a stalled output, fills a 16-entry
// result queue that stalls the input once it holds more than seven results.
// The line stores are not cleared after reset; the first two rows write them
// before any interior pixel reads them. Change the registers only while idle.
module rgb_conv3x3_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rgbc_pkg::pix_in_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rgbc_pkg::pix_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);
  import rgbc_pkg::*;

  logic [1:0]       filter_mode;
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic [WID_W-1:0] wl;
  logic [HGT_W-1:0] hl;

  logic             in_acc;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] c_cur;
  logic [ROW_W-1:0] r_cur;
  logic [WID_W-1:0] c_inc;
  logic [HGT_W-1:0] r_inc;
  logic [31:0]      px_in;

  logic [31:0] upper_mem  [MAX_WIDTH];
  logic [31:0] middle_mem [MAX_WIDTH];
  logic [31:0] up_rd;
  logic [31:0] mid_rd;

  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [31:0]      s1_px;
  logic             s1_hz;
  logic [31:0]      fwd_up;
  logic [31:0]      fwd_mid;
  logic [31:0]      s1_up;
  logic [31:0]      s1_mid;
  win_t             win;
  win_t             win_next;
  logic             emit0;
  logic             emit1;
  logic             emit2;
  logic             interior;

  logic             s2_valid;
  logic             s2_e0;
  logic             s2_e1;
  logic             s2_e2;
  logic             s2_int;
  logic [COL_W-1:0] s2_col;
  logic [ROW_W-1:0] s2_row;
  win_t             s2_win;
  logic [31:0]      s2_b4;
  logic [31:0]      s2_mid;
  logic [31:0]      s2_px;
  logic [23:0]      frgb;
  logic [31:0]      e0_px;

  pix_out_t         res [3];
  logic [1:0]       res_n;
  logic [1:0]       push_n;
  logic             pop;
  pix_out_t         fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_BLUR;
      image_width  <= WID_W'(MAX_WIDTH);
      image_height <= HGT_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   filter_mode  <= cfg_data[1:0];
        CFG_WIDTH:  image_width  <= cfg_data[WID_W-1:0];
        CFG_HEIGHT: image_height <= cfg_data[HGT_W-1:0];
        default:    ;
      endcase
    end
  end

  // effective frame size: zero reads as one, large values saturate
  always_comb begin
    if (image_width == '0) begin
      wl = WID_W'(1);
    end else if (image_width > WID_W'(MAX_WIDTH)) begin
      wl = WID_W'(MAX_WIDTH);
    end else begin
      wl = image_width;
    end
    if (image_height == '0) begin
      hl = HGT_W'(1);
    end else if (image_height > HGT_W'(MAX_HEIGHT)) begin
      hl = HGT_W'(MAX_HEIGHT);
    end else begin
      hl = image_height;
    end
  end

  // input side position
  assign in_acc = in_valid && !in_stall;
  assign c_cur  = ({1'b0, col_cnt} >= wl) ? '0 : col_cnt;
  assign r_cur  = ({1'b0, row_cnt} >= hl) ? '0 : row_cnt;
  assign c_inc  = {1'b0, c_cur} + WID_W'(1);
  assign r_inc  = {1'b0, r_cur} + HGT_W'(1);
  assign px_in  = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_acc) begin
      if (c_inc >= wl) begin
        col_cnt <= '0;
        row_cnt <= (r_inc >= hl) ? '0 : r_inc[ROW_W-1:0];
      end else begin
        col_cnt <= c_inc[COL_W-1:0];
        row_cnt <= r_cur;
      end
    end
  end

  // line stores: read on accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      upper_mem[s1_col] <= s1_mid;
    end
    if (in_acc) begin
      up_rd <= upper_mem[c_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      middle_mem[s1_col] <= s1_px;
    end
    if (in_acc) begin
      mid_rd <= middle_mem[c_cur];
    end
  end

  // stage 1 registers, with bypass when the pending write hits the read column
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col  <= c_cur;
      s1_row  <= r_cur;
      s1_px   <= px_in;
      s1_hz   <= s1_valid && (s1_col == c_cur);
      fwd_up  <= s1_mid;
      fwd_mid <= s1_px;
    end
  end

  assign s1_up  = s1_hz ? fwd_up  : up_rd;
  assign s1_mid = s1_hz ? fwd_mid : mid_rd;

  // window slide
  always_comb begin
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = s1_up;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = s1_mid;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // result scheduling for this pixel
  assign emit0    = (s1_row != '0) && (s1_col != '0);
  assign emit1    = (s1_row != '0) && (({1'b0, s1_col} + WID_W'(1)) == wl);
  assign emit2    = (({1'b0, s1_row} + HGT_W'(1)) == hl);
  assign interior = (s1_row > ROW_W'(1)) && (s1_col > COL_W'(1));

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_e0  <= emit0;
      s2_e1  <= emit1;
      s2_e2  <= emit2;
      s2_int <= interior;
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_win <= win_next;
      s2_b4  <= win_next[4];
      s2_mid <= s1_mid;
      s2_px  <= s1_px;
    end
  end

  rgbc_filter u_filter (
    .win  (s2_win),
    .mode (filter_mode),
    .rgb  (frgb)
  );

  assign e0_px = s2_int ? {8'hFF, frgb} : s2_b4;

  // pack up to three results in order
  always_comb begin
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    res_n  = 2'd0;
    if (s2_e0) begin
      res[res_n] = '{out_col: s2_col - COL_W'(1), out_row: s2_row - ROW_W'(1),
                     red_out: e0_px[7:0], green_out: e0_px[15:8],
                     blue_out: e0_px[23:16], alpha_out: e0_px[31:24],
                     last_of_run: !s2_e1 && !s2_e2};
      res_n = res_n + 2'd1;
    end
    if (s2_e1) begin
      res[res_n] = '{out_col: s2_col, out_row: s2_row - ROW_W'(1),
                     red_out: s2_mid[7:0], green_out: s2_mid[15:8],
                     blue_out: s2_mid[23:16], alpha_out: s2_mid[31:24],
                     last_of_run: !s2_e2};
      res_n = res_n + 2'd1;
    end
    if (s2_e2) begin
      res[res_n] = '{out_col: s2_col, out_row: s2_row,
                     red_out: s2_px[7:0], green_out: s2_px[15:8],
                     blue_out: s2_px[23:16], alpha_out: s2_px[31:24],
                     last_of_run: 1'b1};
      res_n = res_n + 2'd1;
    end
  end

  assign push_n = s2_valid ? res_n : 2'd0;

  // result queue
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (FIFO_CW'(j) < FIFO_CW'(push_n)) begin
        fifo_mem[wr_ptr + FIFO_AW'(j)] <= res[j];
      end
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = fifo_mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (count > FIFO_CW'(ACCEPT_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rgbc_checker.sv @@
// rgbc_checker: port level assertions for rgb_conv3x3_filter, bound to the top level
// depends on rgbc_pkg
`default_nettype none

module rgbc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input rgbc_pkg::pix_in_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input rgbc_pkg::pix_out_t out_data,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input logic [12:0]        cfg_data
);
  import rgbc_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  // reset leaves an empty queue and an open input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

  // the results of one pixel are queued together, so a run never breaks
  a_run_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_of_run |=> out_valid)
    else $error("result run broken");

  // rows never skip back within a run
  a_run_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_of_run |=>
      out_data.out_row >= $past(out_data.out_row))
    else $error("row order broken within a run");

endmodule

bind rgb_conv3x3_filter rgbc_checker u_rgbc_checker (.*);

`default_nettype wire
